/* design/csrmv_pkg.sv */
// shared types and constants of the csr sparse matrix-vector row accumulator
package csrmv_pkg;

  // field widths
  localparam int unsigned REQ_TYPE_W = 2;
  localparam int unsigned COL_W      = 10;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned ACC_W      = 64;
  localparam int unsigned ROW_W      = 16;
  localparam int unsigned NROWS_W    = 17;
  localparam int unsigned ALPHA_W    = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 17;

  // saturation limits of the q32.32 accumulator
  localparam logic [ACC_W-1:0] SAT_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] SAT_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // row count used when num_rows is zero or too large
  localparam logic [NROWS_W-1:0] NROWS_FULL = NROWS_W'(65536);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 1'd1;

  // item kinds
  typedef enum logic [REQ_TYPE_W-1:0] {
    REQ_LOAD   = 2'd0,
    REQ_NZ     = 2'd1,
    REQ_NZ_END = 2'd2,
    REQ_EMPTY  = 2'd3
  } req_type_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic mem_wr;
    logic mem_rd;
    logic mul;
    logic acc;
    logic scale;
    logic commit;
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    req_type_e req_type;
  } sts_t;

endpackage

/* design/csrmv_req_if.sv */
// request channel: one item carries an x load, a nonzero or an empty row
interface csrmv_req_if import csrmv_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [REQ_TYPE_W-1:0] req_type;
  logic [COL_W-1:0]      col_index;
  logic [VAL_W-1:0]      matrix_value;
  logic [VAL_W-1:0]      x_value;

  modport source (output valid, req_type, col_index, matrix_value, x_value, input ready);
  modport sink   (input valid, req_type, col_index, matrix_value, x_value, output ready);
endinterface

/* design/csrmv_res_if.sv */
// result channel: one item per finished row
interface csrmv_res_if import csrmv_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_index;
  logic [ACC_W-1:0] row_result;
  logic             last_row;
  logic             saturated;

  modport source (output valid, row_index, row_result, last_row, saturated, input ready);
  modport sink   (input valid, row_index, row_result, last_row, saturated, output ready);
endinterface

/* design/csrmv_ctrl.sv */
// controller: sequences one item at a time through the datapath
module csrmv_ctrl import csrmv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  output logic res_valid_o,
  input  logic res_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADDR,
    ST_MUL,
    ST_ACC,
    ST_SCALE,
    ST_COMMIT
  } state_e;

  state_e state_q, state_d;
  logic   res_valid_q, res_valid_d;
  logic   out_free;

  // output register can take a result when empty or being emptied
  assign out_free    = !res_valid_q || res_ready_i;
  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = res_valid_q;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_ADDR;
        end
      end
      ST_ADDR: begin
        case (sts_i.req_type)
          REQ_LOAD: begin
            cmd_o.mem_wr = 1'b1;
            state_d      = ST_IDLE;
          end
          REQ_EMPTY: state_d = ST_SCALE;
          default: begin
            cmd_o.mem_rd = 1'b1;
            state_d      = ST_MUL;
          end
        endcase
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = (sts_i.req_type == REQ_NZ) ? ST_IDLE : ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    res_valid_d = res_valid_q;
    if (res_valid_q && res_ready_i) res_valid_d = 1'b0;
    if (cmd_o.commit) res_valid_d = 1'b1;
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

endmodule

/* design/csrmv_dp.sv */
// datapath: x store, multiply, saturating accumulate, alpha scaling, result register
module csrmv_dp import csrmv_pkg::*; #(
  parameter int unsigned X_DEPTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic [REQ_TYPE_W-1:0] req_type_i,
  input  logic [COL_W-1:0]      col_index_i,
  input  logic [VAL_W-1:0]      matrix_value_i,
  input  logic [VAL_W-1:0]      x_value_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output logic [ROW_W-1:0]      row_index_o,
  output logic [ACC_W-1:0]      row_result_o,
  output logic                  last_row_o,
  output logic                  saturated_o
);

  localparam int unsigned AW = $clog2(X_DEPTH);
  localparam int unsigned MW = ALPHA_W;
  localparam int unsigned PW = VAL_W + MW;

  // configuration
  logic [NROWS_W-1:0] num_rows_q;
  logic [ALPHA_W-1:0] alpha_q;

  // captured item
  req_type_e          type_q;
  logic [COL_W-1:0]   col_q, col_d;
  logic [VAL_W-1:0]   mat_q;
  logic [VAL_W-1:0]   xval_q;

  // x store
  logic [VAL_W-1:0]   x_mem [X_DEPTH];
  logic [VAL_W-1:0]   rdata_q;
  logic [COL_W-1:0]   col_red;
  logic [AW-1:0]      addr;

  // arithmetic state
  logic signed [ACC_W-1:0] prod_q;
  logic [ACC_W-1:0]        acc_q;
  logic                    ovf_q;
  logic [ROW_W-1:0]        row_cnt_q;
  logic [ACC_W:0]          sum;
  logic [ACC_W-1:0]        acc_d;
  logic                    acc_ovf;

  // scaling stage
  logic                    neg_q, zero_q;
  logic [PW-1:0]           lo_q, hi_q;
  logic [ACC_W-1:0]        mag;
  logic [MW-1:0]           mult;
  logic [PW:0]             top;
  logic [ACC_W-1:0]        limit, sprod, scaled;
  logic                    scale_ovf;

  // row bookkeeping
  logic [NROWS_W-1:0]      nrows_eff;
  logic                    is_last;

  // output register
  logic [ROW_W-1:0]        row_index_q;
  logic [ACC_W-1:0]        row_result_q;
  logic                    last_row_q, saturated_q;

  assign sts_o.req_type = type_q;

  // column reduction modulo depth, upper steps before capture
  always_comb begin
    col_d = col_index_i;
    for (int k = 9; k >= 5; k--) begin
      if (32'(col_d) >= (X_DEPTH << k)) col_d = col_d - COL_W'(X_DEPTH << k);
    end
  end

  // column reduction, lower steps on the captured column
  always_comb begin
    col_red = col_q;
    for (int k = 4; k >= 0; k--) begin
      if (32'(col_red) >= (X_DEPTH << k)) col_red = col_red - COL_W'(X_DEPTH << k);
    end
    addr = AW'(col_red);
  end

  // x store write and registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) x_mem[addr] <= xval_q;
    if (cmd_i.mem_rd) rdata_q <= x_mem[addr];
  end

  // item capture and product register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      col_q  <= col_d;
      mat_q  <= matrix_value_i;
      xval_q <= x_value_i;
    end
    if (cmd_i.mul) prod_q <= signed'(mat_q) * signed'(rdata_q);
  end

  // saturating accumulate
  always_comb begin
    sum     = {acc_q[ACC_W-1], acc_q} + {prod_q[ACC_W-1], prod_q};
    acc_ovf = sum[ACC_W] != sum[ACC_W-1];
    if (acc_ovf) acc_d = sum[ACC_W] ? SAT_MIN : SAT_MAX;
    else         acc_d = sum[ACC_W-1:0];
  end

  // magnitudes for scaling
  always_comb begin
    mag  = acc_q[ACC_W-1] ? (ACC_W'(0) - acc_q) : acc_q;
    mult = alpha_q[ALPHA_W-1] ? (MW'(0) - alpha_q) : alpha_q;
  end

  // product of the two halves of the magnitude with alpha
  always_ff @(posedge clk_i) begin
    if (cmd_i.scale) begin
      lo_q   <= PW'(mag[31:0]) * PW'(mult);
      hi_q   <= PW'(mag[63:32]) * PW'(mult);
      neg_q  <= acc_q[ACC_W-1] ^ alpha_q[ALPHA_W-1];
      zero_q <= (acc_q == '0) || (alpha_q == '0);
    end
  end

  // combine halves, saturate and restore sign
  always_comb begin
    top       = {1'b0, hi_q} + (PW+1)'(lo_q[PW-1:32]);
    limit     = neg_q ? SAT_MIN : SAT_MAX;
    sprod     = {top[31:0], lo_q[31:0]};
    scale_ovf = 1'b0;
    scaled    = '0;
    if (!zero_q) begin
      if (top > (PW+1)'(33'h0_8000_0000) || sprod > limit) begin
        scale_ovf = 1'b1;
        scaled    = limit;
      end else begin
        scaled = neg_q ? (ACC_W'(0) - sprod) : sprod;
      end
    end
  end

  // last row detection
  always_comb begin
    nrows_eff = (num_rows_q == '0 || num_rows_q > NROWS_FULL) ? NROWS_FULL : num_rows_q;
    is_last   = {1'b0, row_cnt_q} == (nrows_eff - NROWS_W'(1));
  end

  // configuration, accumulator and row counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= NROWS_W'(1);
      alpha_q    <= ALPHA_W'(1);
      acc_q      <= '0;
      ovf_q      <= 1'b0;
      row_cnt_q  <= '0;
      type_q     <= REQ_LOAD;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_NUM_ROWS: num_rows_q <= cfg_wdata_i[NROWS_W-1:0];
          CFG_ALPHA:    alpha_q    <= cfg_wdata_i[ALPHA_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.capture) type_q <= req_type_e'(req_type_i);
      if (cmd_i.acc) begin
        acc_q <= acc_d;
        if (acc_ovf) ovf_q <= 1'b1;
      end
      if (cmd_i.commit) begin
        acc_q     <= '0;
        ovf_q     <= 1'b0;
        row_cnt_q <= is_last ? '0 : row_cnt_q + ROW_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      row_index_q  <= row_cnt_q;
      row_result_q <= scaled;
      last_row_q   <= is_last;
      saturated_q  <= ovf_q | scale_ovf;
    end
  end

  assign row_index_o  = row_index_q;
  assign row_result_o = row_result_q;
  assign last_row_o   = last_row_q;
  assign saturated_o  = saturated_q;

endmodule

/* design/csr_sparse_matvec_row_accumulator.sv */
// top level of the csr sparse matrix-vector row accumulator
//
// Computes alpha * A * x one row at a time. The request channel carries items
// of four kinds: x loads into the internal store, nonzeros, nonzeros that end
// a row, and empty rows. Each row-ending item yields one result item with the
// row index, the saturated q32.32 row result, a last-row flag and a saturation
// flag. The user writes num_rows and alpha on the configuration port while
// idle; the block does not enforce this. One item is in flight at a time. A
// load steps through capture and store write, a nonzero through capture,
// registered store read, multiply and accumulate, and a row-ending nonzero
// adds alpha scaling and commit; an empty row takes capture, scale and commit.
// Results sit in an output register, so the next item is accepted while a
// result waits; if the receiver stalls, a further row result waits in the
// controller until the register frees up.
// Reset clears the accumulator, the row counter and the overflow flag and sets
// num_rows and alpha to one; the x store holds nothing until loaded.
module csr_sparse_matvec_row_accumulator import csrmv_pkg::*; #(
  parameter int unsigned X_DEPTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  csrmv_req_if.sink             req_i,
  csrmv_res_if.source           res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  csrmv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // arithmetic and storage
  csrmv_dp #(
    .X_DEPTH (X_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .req_type_i     (req_i.req_type),
    .col_index_i    (req_i.col_index),
    .matrix_value_i (req_i.matrix_value),
    .x_value_i      (req_i.x_value),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .row_index_o    (res_o.row_index),
    .row_result_o   (res_o.row_result),
    .last_row_o     (res_o.last_row),
    .saturated_o    (res_o.saturated)
  );

endmodule
